// ----- hw/rtl/pqa_pkg.sv -----
// ----------------------------------------------------------------------------
// pqa_pkg: shared types and constants of the aging priority queue
// Opcode and status codes, transfer payloads, cell control, priority aging.
// ----------------------------------------------------------------------------
package pqa_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ID_W      = 10;
	localparam int PRIO_W    = 4;
	localparam int OCC_W     = 5;

	localparam logic [ID_W-1:0]   ID_MAX   = 10'd1023;
	localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd15;
	localparam logic [PRIO_W-1:0] PRIO_MIN = 4'd1;

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_RETRIEVE = 2'd1,
		OP_CLOSE    = 2'd2,
		OP_NOP      = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_CLOSED = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ID_W-1:0]   entry_id;
		logic [PRIO_W-1:0] entry_priority;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   head_id;
		logic [OCC_W-1:0]  occupancy;
	} out_item_t;

	// Broadcast to every cell in the chain
	typedef struct packed {
		logic              insert;
		logic              retrieve;
		logic [ID_W-1:0]   new_id;
		logic [PRIO_W-1:0] new_prio;
	} cell_ctrl_t;

	// Age one priority step, never below the minimum
	function automatic logic [PRIO_W-1:0] age_prio(input logic [PRIO_W-1:0] p);
		logic [PRIO_W-1:0] r;
		r = (p > PRIO_MIN) ? p - PRIO_MIN : p;
		return r;
	endfunction

endpackage

// ----- hw/rtl/pqa_cell.sv -----
// ----------------------------------------------------------------------------
// pqa_cell: one slot of the sorted queue chain
// Holds one entry; shifts toward the tail on insert, toward the head on
// retrieve with aging.
// ----------------------------------------------------------------------------
module pqa_cell (
	input  logic                           clk,
	input  pqa_pkg::cell_ctrl_t            ctrl,
	input  logic                           live,
	input  logic                           prev_open,
	input  logic [pqa_pkg::ID_W-1:0]       prev_id,
	input  logic [pqa_pkg::PRIO_W-1:0]     prev_prio,
	input  logic [pqa_pkg::ID_W-1:0]       next_id,
	input  logic [pqa_pkg::PRIO_W-1:0]     next_prio,
	output logic                           open,
	output logic [pqa_pkg::ID_W-1:0]       id,
	output logic [pqa_pkg::PRIO_W-1:0]     prio
);
	import pqa_pkg::*;

	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] prio_q;

	// Open: the new entry lands here or further toward the head
	assign open = !live || (prio_q > ctrl.new_prio);
	assign id   = id_q;
	assign prio = prio_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert && open) begin
			if (prev_open) begin
				id_q   <= prev_id;
				prio_q <= prev_prio;
			end else begin
				id_q   <= ctrl.new_id;
				prio_q <= ctrl.new_prio;
			end
		end else if (ctrl.retrieve) begin
			id_q   <= next_id;
			prio_q <= age_prio(next_prio);
		end
	end

endmodule

// ----- hw/rtl/priority_queue_with_aging_core.sv -----
// The result of each input transfer is registered in the output register.
// Throughput: one operation per cycle; every cell compares and shifts at once.
// Back-pressure on the output stalls the input only while the result is held.
// Reset clears the entry count, the closed flag and the output valid; cell
// contents are not reset and are only read below the entry count.
// ----------------------------------------------------------------------------
// priority_queue_with_aging_core: sorted priority queue with aging
// A chain of DEPTH cells kept in priority order, head at cell 0. Inserts
// open a gap by shifting larger priorities toward the tail; retrieves pop
// cell 0 and shift the rest toward the head while aging them.
// ----------------------------------------------------------------------------
module priority_queue_with_aging_core #(
	parameter int DEPTH = pqa_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pqa_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pqa_pkg::out_item_t  out_data
);
	import pqa_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic              in_xfer;
	logic [CNT_W-1:0]  count_q;
	logic              closed_q;
	logic              full;
	logic              empty;

	logic [ID_W-1:0]   id_sat;
	logic [PRIO_W-1:0] prio_sat;

	cell_ctrl_t        ctrl;
	logic [CNT_W-1:0]  count_d;
	logic              closed_d;
	status_t           status_d;
	logic [ID_W-1:0]   head_d;

	// Cell chain taps
	logic              cell_open [DEPTH];
	logic [ID_W-1:0]   cell_id   [DEPTH];
	logic [PRIO_W-1:0] cell_prio [DEPTH];

	out_item_t         out_q;

	// Hold the result until it is taken; accept the next one in the same cycle
	assign in_ready = !out_valid || out_ready;
	assign in_xfer  = in_valid && in_ready;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// Saturate the incoming entry into its legal range
	always_comb begin
		id_sat = (in_data.entry_id > ID_MAX) ? ID_MAX : in_data.entry_id;
		if (in_data.entry_priority < PRIO_MIN) begin
			prio_sat = PRIO_MIN;
		end else if (in_data.entry_priority > PRIO_MAX) begin
			prio_sat = PRIO_MAX;
		end else begin
			prio_sat = in_data.entry_priority;
		end
	end

	// Decode the operation; closed wins over full and empty
	always_comb begin
		ctrl.insert   = 1'b0;
		ctrl.retrieve = 1'b0;
		ctrl.new_id   = id_sat;
		ctrl.new_prio = prio_sat;
		count_d       = count_q;
		closed_d      = closed_q;
		status_d      = ST_OK;
		head_d        = '0;
		case (opcode_t'(in_data.opcode))
			OP_INSERT: begin
				if (closed_q) begin
					status_d = ST_CLOSED;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.insert = in_xfer;
					count_d     = count_q + 1'b1;
				end
			end
			OP_RETRIEVE: begin
				if (closed_q) begin
					status_d = ST_CLOSED;
				end else if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					ctrl.retrieve = in_xfer;
					head_d        = cell_id[0];
					count_d       = count_q - 1'b1;
				end
			end
			OP_CLOSE: begin
				closed_d = 1'b1;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Build the chain; head sits at cell 0, the tail side at DEPTH-1
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic              live;
		logic              p_open;
		logic [ID_W-1:0]   p_id;
		logic [PRIO_W-1:0] p_prio;
		logic [ID_W-1:0]   n_id;
		logic [PRIO_W-1:0] n_prio;

		assign live = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign p_open = 1'b0;
			assign p_id   = '0;
			assign p_prio = '0;
		end else begin : g_mid
			assign p_open = cell_open[i-1];
			assign p_id   = cell_id[i-1];
			assign p_prio = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign n_id   = '0;
			assign n_prio = '0;
		end else begin : g_inner
			assign n_id   = cell_id[i+1];
			assign n_prio = cell_prio[i+1];
		end

		pqa_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.live      (live),
			.prev_open (p_open),
			.prev_id   (p_id),
			.prev_prio (p_prio),
			.next_id   (n_id),
			.next_prio (n_prio),
			.open      (cell_open[i]),
			.id        (cell_id[i]),
			.prio      (cell_prio[i])
		);
	end

	// Advance queue state and register the result on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			closed_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_xfer) begin
				count_q   <= count_d;
				closed_q  <= closed_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Result payload needs no reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_q.status    <= status_d;
			out_q.head_id   <= head_d;
			out_q.occupancy <= OCC_W'(count_d);
		end
	end

	assign out_data = out_q;

endmodule
